>>> hdl/uff_pkg.sv
// Shared types, constants and ring helpers for the UART buffering block
`default_nettype none

package uff_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // Field widths
  localparam int REQ_W  = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  // Flow control characters
  localparam logic [BYTE_W-1:0] CHAR_XOFF = 8'd19;
  localparam logic [BYTE_W-1:0] CHAR_XON  = 8'd17;

  // Flow flag bit positions
  localparam int FLB_SEND_XOFF = 0;
  localparam int FLB_SEND_XON  = 1;
  localparam int FLB_SENT_XOFF = 2;
  localparam int FLB_SENT_XON  = 3;
  localparam int FLAG_W        = 4;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_RX_BYTE  = 3'd0,
    REQ_RX_POP   = 3'd1,
    REQ_TX_WRITE = 3'd2,
    REQ_TX_SLOT  = 3'd3,
    REQ_XON      = 3'd4,
    REQ_XOFF     = 3'd5
  } req_t;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Register map
  localparam int                ADDR_W         = 3;
  localparam logic [ADDR_W-1:0] ADDR_FLOW_CTRL = 3'd0;

  // Result item, read_byte in the lowest bits
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  tx_space;
    logic [CNT_W-1:0]  rx_count;
    logic [BYTE_W-1:0] line_byte;
    logic              line_valid;
    logic [BYTE_W-1:0] read_byte;
  } res_t;

  localparam int RES_W   = $bits(res_t);
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  // Entries held between tail and head
  function automatic logic [PTR_W-1:0] ring_used(input logic [PTR_W-1:0] h,
                                                 input logic [PTR_W-1:0] t);
    if (h >= t) begin
      return h - t;
    end else begin
      return h + PTR_W'(RING_DEPTH) - t;
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/uart_fifo_xon_xoff.sv
// Top level: receive and transmit rings with XON/XOFF flow control
// Results are registered: pushes, flow requests and flow characters load the
// output register (or the pending slot) on the input transfer; a pop or a
// transmit slot that reads a ring memory goes through its synchronous read and
// the READ state first. Throughput: one item per cycle while the output is free
// and no ring read is under way; a pending slot lets the next item enter while a result waits.
// Reset (rst, synchronous): pointers, flow flags and flow enable clear.
`default_nettype none

module uart_fifo_xon_xoff (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic [2:0]                    s_tuser,   // [2:0] req_type
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [uff_pkg::TDATA_W-1:0]   m_tdata,   // [7:0] read_byte, [8] line_valid,
                                                   // [16:9] line_byte, [23:17] rx_count,
                                                   // [30:24] tx_space, [32:31] status
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uff_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_HOLD} state_t;

  state_t                          state;
  logic [uff_pkg::PTR_W-1:0]       rx_head, rx_tail, tx_head, tx_tail;
  logic [uff_pkg::PTR_W-1:0]       rx_head_next, rx_tail_next, tx_head_next, tx_tail_next;
  logic [uff_pkg::FLAG_W-1:0]      flags, flags_next;
  logic                            fc_en;
  uff_pkg::res_t                   res, res_c, res_fill, out_res;
  logic                            rd_tx, rd_tx_c, need_read;
  logic                            rx_we, rx_re, tx_we, tx_re;
  logic [uff_pkg::BYTE_W-1:0]      rx_rd, tx_rd;
  logic [uff_pkg::BYTE_W-1:0]      rx_mem [uff_pkg::RING_DEPTH];
  logic [uff_pkg::BYTE_W-1:0]      tx_mem [uff_pkg::RING_DEPTH];
  logic [uff_pkg::PTR_W-1:0]       rx_used, tx_used, rx_used_n, tx_used_n;
  logic                            accept, out_free, out_load, cfg_wr;
  uff_pkg::req_t                   req;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign req      = uff_pkg::req_t'(s_tuser);
  assign rx_used  = uff_pkg::ring_used(rx_head, rx_tail);
  assign tx_used  = uff_pkg::ring_used(tx_head, tx_tail);

  // Load the output register when a result is ready and the slot is free
  assign out_load = out_free && (((state == ST_IDLE) && accept && !need_read) ||
                                 (state == ST_READ) || (state == ST_HOLD));

  // Decode one request into pointer, flag and result updates
  always_comb begin
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    flags_next   = flags;
    res_c        = '0;
    need_read    = 1'b0;
    rd_tx_c      = 1'b0;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    unique case (req)
      uff_pkg::REQ_RX_BYTE: begin
        if (rx_used != uff_pkg::PTR_W'(uff_pkg::RING_DEPTH - 1)) begin
          rx_we        = accept;
          rx_head_next = uff_pkg::ring_next(rx_head);
        end else begin
          res_c.status = uff_pkg::STAT_FULL;
        end
      end
      uff_pkg::REQ_RX_POP: begin
        if (rx_used != '0) begin
          need_read    = 1'b1;
          rx_tail_next = uff_pkg::ring_next(rx_tail);
        end else begin
          res_c.status = uff_pkg::STAT_EMPTY;
        end
      end
      uff_pkg::REQ_TX_WRITE: begin
        if (tx_used != uff_pkg::PTR_W'(uff_pkg::RING_DEPTH - 1)) begin
          tx_we        = accept;
          tx_head_next = uff_pkg::ring_next(tx_head);
        end else begin
          res_c.status = uff_pkg::STAT_FULL;
        end
      end
      uff_pkg::REQ_TX_SLOT: begin
        if (fc_en && flags[uff_pkg::FLB_SEND_XOFF]) begin
          res_c.line_valid                    = 1'b1;
          res_c.line_byte                     = uff_pkg::CHAR_XOFF;
          flags_next[uff_pkg::FLB_SEND_XOFF]  = 1'b0;
          flags_next[uff_pkg::FLB_SENT_XOFF]  = 1'b1;
        end else if (fc_en && flags[uff_pkg::FLB_SEND_XON]) begin
          res_c.line_valid                    = 1'b1;
          res_c.line_byte                     = uff_pkg::CHAR_XON;
          flags_next[uff_pkg::FLB_SEND_XON]   = 1'b0;
          flags_next[uff_pkg::FLB_SENT_XON]   = 1'b1;
        end else if (tx_used != '0) begin
          res_c.line_valid = 1'b1;
          need_read        = 1'b1;
          rd_tx_c          = 1'b1;
          tx_tail_next     = uff_pkg::ring_next(tx_tail);
        end
      end
      uff_pkg::REQ_XON: begin
        if (flags[uff_pkg::FLB_SENT_XOFF]) begin
          flags_next                        = '0;
          flags_next[uff_pkg::FLB_SEND_XON] = 1'b1;
        end
      end
      uff_pkg::REQ_XOFF: begin
        flags_next                         = '0;
        flags_next[uff_pkg::FLB_SEND_XOFF] = 1'b1;
      end
      default: begin
      end
    endcase
    rx_used_n      = uff_pkg::ring_used(rx_head_next, rx_tail_next);
    tx_used_n      = uff_pkg::ring_used(tx_head_next, tx_tail_next);
    res_c.rx_count = uff_pkg::CNT_W'(rx_used_n);
    res_c.tx_space = uff_pkg::CNT_W'(uff_pkg::PTR_W'(uff_pkg::RING_DEPTH - 1) - tx_used_n);
  end

  assign rx_re = accept && need_read && !rd_tx_c;
  assign tx_re = accept && need_read && rd_tx_c;

  // Merge the ring read data into the held result
  always_comb begin
    res_fill = res;
    if (rd_tx) begin
      res_fill.line_byte = tx_rd;
    end else begin
      res_fill.read_byte = rx_rd;
    end
  end

  // Receive ring memory
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_head] <= s_tdata;
    end
    if (rx_re) begin
      rx_rd <= rx_mem[rx_tail];
    end
  end

  // Transmit ring memory
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_head] <= s_tdata;
    end
    if (tx_re) begin
      tx_rd <= tx_mem[tx_tail];
    end
  end

  // Sequence items, hold pointers, flags and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      rx_head  <= '0;
      rx_tail  <= '0;
      tx_head  <= '0;
      tx_tail  <= '0;
      flags    <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        rx_head <= rx_head_next;
        rx_tail <= rx_tail_next;
        tx_head <= tx_head_next;
        tx_tail <= tx_tail_next;
        flags   <= flags_next;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (need_read) begin
              res   <= res_c;
              rd_tx <= rd_tx_c;
              state <= ST_READ;
            end else if (out_free) begin
              out_res <= res_c;
            end else begin
              res   <= res_c;
              state <= ST_HOLD;
            end
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_res <= res_fill;
            state   <= ST_IDLE;
          end else begin
            res   <= res_fill;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_res <= res;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = uff_pkg::TDATA_W'(out_res);

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fc_en <= 1'b0;
    end else if (cfg_wr && (paddr == uff_pkg::ADDR_FLOW_CTRL)) begin
      fc_en <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == uff_pkg::ADDR_FLOW_CTRL) begin
      prdata[0] = fc_en;
    end
  end

endmodule

`default_nettype wire

>>> hdl/uff_checker.sv
// Port-level checks for the UART buffering block, bound to its top level
`default_nettype none

module uff_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [uff_pkg::TDATA_W-1:0] m_tdata
);

  uff_pkg::res_t r;

  assign r = uff_pkg::res_t'(m_tdata[uff_pkg::RES_W-1:0]);

  // Results hold while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A pop of an empty ring returns zero and reports an empty receive ring
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r.status == uff_pkg::STAT_EMPTY) |->
      (r.read_byte == '0) && (r.rx_count == '0) && !r.line_valid)
    else $error("empty pop result inconsistent");

  // No byte goes to the line without its valid flag
  a_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r.line_valid |-> (r.line_byte == '0))
    else $error("line byte without valid");

  // A dropped byte means one ring is full
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r.status == uff_pkg::STAT_FULL) |->
      (r.rx_count == uff_pkg::CNT_W'(uff_pkg::RING_DEPTH - 1)) || (r.tx_space == '0))
    else $error("drop reported with room left");

  // Reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind uart_fifo_xon_xoff uff_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/uart_fifo_xon_xoff_tb.sv
// Stream-level testbench for the UART buffering block with XON/XOFF flow control
module uart_fifo_xon_xoff_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uff_pkg::*;

  // Request codes outside the defined set; the block must ignore them
  localparam logic [REQ_W-1:0]  REQ_SPARE_6   = 3'd6;
  localparam logic [REQ_W-1:0]  REQ_SPARE_7   = 3'd7;
  // Address of a register slot that does not exist
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
  localparam logic [CNT_W-1:0]  RING_CAP      = CNT_W'(RING_DEPTH - 1);

  typedef struct {
    logic [REQ_W-1:0]  code;
    logic [BYTE_W-1:0] data;
    bit                drain_first;
  } uart_item_t;

  typedef enum int {
    B_RX_FILL, B_RX_DRAIN, B_TX_FILL, B_TX_DRAIN, B_FLOW, B_MIXED
  } burst_kind_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;    // [7:0] data_byte
  logic [2:0]          s_tuser = '0;    // [2:0] req_type
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;         // [7:0] read_byte, [8] line_valid,
                                        // [16:9] line_byte, [23:17] rx_count,
                                        // [30:24] tx_space, [32:31] status
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  uart_fifo_xon_xoff dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted block state
  logic [BYTE_W-1:0] rx_mem [RING_DEPTH];
  logic [BYTE_W-1:0] tx_mem [RING_DEPTH];
  logic [PTR_W-1:0]  rx_head = '0, rx_tail = '0, tx_head = '0, tx_tail = '0;
  logic [FLAG_W-1:0] flow_flags = '0;
  logic              flow_en = 1'b0;

  uart_item_t req_items_q[$];
  res_t       uart_results_q[$];
  uart_item_t drive_item;
  res_t       want_res, got_res;
  bit         results_drained = 1'b1;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         fail_count = 0;

  // Compute one result and advance the predicted rings and flow flags
  function automatic res_t uart_buffer_step(input logic [REQ_W-1:0] code,
                                            input logic [BYTE_W-1:0] data);
    res_t r;
    r = '0;
    case (code)
      REQ_RX_BYTE: begin
        if (CNT_W'(rx_head - rx_tail) != RING_CAP) begin
          rx_mem[rx_head] = data;
          rx_head = rx_head + 1'b1;
        end else begin
          r.status = STAT_FULL;
        end
      end
      REQ_RX_POP: begin
        if (rx_head != rx_tail) begin
          r.read_byte = rx_mem[rx_tail];
          rx_tail = rx_tail + 1'b1;
        end else begin
          r.status = STAT_EMPTY;
        end
      end
      REQ_TX_WRITE: begin
        if (CNT_W'(tx_head - tx_tail) != RING_CAP) begin
          tx_mem[tx_head] = data;
          tx_head = tx_head + 1'b1;
        end else begin
          r.status = STAT_FULL;
        end
      end
      REQ_TX_SLOT: begin
        if (flow_en && flow_flags[FLB_SEND_XOFF]) begin
          r.line_valid = 1'b1;
          r.line_byte = CHAR_XOFF;
          flow_flags[FLB_SEND_XOFF] = 1'b0;
          flow_flags[FLB_SENT_XOFF] = 1'b1;
        end else if (flow_en && flow_flags[FLB_SEND_XON]) begin
          r.line_valid = 1'b1;
          r.line_byte = CHAR_XON;
          flow_flags[FLB_SEND_XON] = 1'b0;
          flow_flags[FLB_SENT_XON] = 1'b1;
        end else if (tx_head != tx_tail) begin
          r.line_valid = 1'b1;
          r.line_byte = tx_mem[tx_tail];
          tx_tail = tx_tail + 1'b1;
        end
      end
      REQ_XON: begin
        if (flow_flags[FLB_SENT_XOFF]) begin
          flow_flags = '0;
          flow_flags[FLB_SEND_XON] = 1'b1;
        end
      end
      REQ_XOFF: begin
        flow_flags = '0;
        flow_flags[FLB_SEND_XOFF] = 1'b1;
      end
      default: ;
    endcase
    r.rx_count = CNT_W'(rx_head - rx_tail);
    r.tx_space = RING_CAP - CNT_W'(tx_head - tx_tail);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic add_item(input logic [REQ_W-1:0] code, input logic [BYTE_W-1:0] data,
                          input bit drain_first = 1'b0);
    uart_item_t it;
    it.code = code;
    it.data = data;
    it.drain_first = drain_first;
    req_items_q.push_back(it);
  endtask

  // Fill the pending queue with bursts of well-formed traffic plus noise
  task automatic build_segment(input int seg);
    int added;
    int len;
    int n;
    burst_kind_t kind;
    added = 0;
    // drive one ring past full in two of the segments
    if (seg == 2) begin
      for (int i = 0; i < 132; i++) add_item(REQ_RX_BYTE, 8'($urandom));
      added = 132;
    end else if (seg == 5) begin
      for (int i = 0; i < 132; i++) add_item(REQ_TX_WRITE, 8'($urandom));
      added = 132;
    end
    while (added < 130) begin
      kind = burst_kind_t'($urandom_range(0, 5));
      len = $urandom_range(1, 48);
      case (kind)
        B_RX_FILL:  for (int i = 0; i < len; i++) add_item(REQ_RX_BYTE, 8'($urandom));
        B_RX_DRAIN: for (int i = 0; i < len; i++) add_item(REQ_RX_POP, 8'($urandom));
        B_TX_FILL:  for (int i = 0; i < len; i++) add_item(REQ_TX_WRITE, 8'($urandom));
        B_TX_DRAIN: for (int i = 0; i < len; i++) add_item(REQ_TX_SLOT, 8'($urandom));
        B_FLOW: begin
          // xoff, some data, slots, xon, slots
          add_item(REQ_XOFF, 8'($urandom), $urandom_range(0, 3) == 0);
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) add_item(REQ_TX_WRITE, 8'($urandom));
          add_item(REQ_TX_SLOT, 8'($urandom));
          add_item(REQ_TX_SLOT, 8'($urandom));
          add_item(REQ_XON, 8'($urandom));
          if ($urandom_range(0, 1)) add_item(REQ_XON, 8'($urandom));
          add_item(REQ_TX_SLOT, 8'($urandom));
          add_item(REQ_TX_SLOT, 8'($urandom));
          len = n + 7;
        end
        default: begin
          for (int i = 0; i < len; i++) begin
            add_item(3'($urandom_range(0, 7)), 8'($urandom));
          end
        end
      endcase
      added += len;
    end
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_FLOW_CTRL) flow_en = value[0];
    @(negedge clk);
  endtask

  // Wait until every item is accepted and every result has arrived
  task automatic wait_idle();
    do @(negedge clk);
    while (req_items_q.size() != 0 || s_tvalid || uart_results_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // Sender: hold an item until transferred, idle at random between items
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (req_items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
          (!req_items_q[0].drain_first || (!s_tvalid && results_drained))) begin
        drive_item = req_items_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= drive_item.data;
        s_tuser <= drive_item.code;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(negedge clk) begin
    results_drained <= (uart_results_q.size() == 0);
  end

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        uart_results_q.push_back(uart_buffer_step(s_tuser, s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got_res = res_t'(m_tdata[RES_W-1:0]);
        if (uart_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got_res);
          fail_count++;
        end else begin
          want_res = uart_results_q.pop_front();
          check_field("read_byte", want_res.read_byte, got_res.read_byte);
          check_field("line_valid", want_res.line_valid, got_res.line_valid);
          check_field("line_byte", want_res.line_byte, got_res.line_byte);
          check_field("rx_count", want_res.rx_count, got_res.rx_count);
          check_field("tx_space", want_res.tx_space, got_res.tx_space);
          check_field("status", want_res.status, got_res.status);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty cases, byte extremes, flow requests with flow control off
    reg_write(ADDR_FLOW_CTRL, 32'd0);
    add_item(REQ_RX_POP, 8'h00);
    add_item(REQ_TX_SLOT, 8'hFF);
    add_item(REQ_RX_BYTE, 8'h00);
    add_item(REQ_RX_BYTE, 8'hFF);
    add_item(REQ_RX_BYTE, 8'hA5);
    repeat (3) add_item(REQ_RX_POP, 8'h5A);
    add_item(REQ_RX_POP, 8'hFF);
    add_item(REQ_TX_WRITE, 8'h00);
    add_item(REQ_TX_WRITE, 8'hFF);
    add_item(REQ_XON, 8'h00);
    add_item(REQ_XOFF, 8'hFF);
    add_item(REQ_TX_SLOT, 8'h00);
    add_item(REQ_SPARE_6, 8'hFF);
    add_item(REQ_SPARE_7, 8'h00);
    wait_idle();

    // Unmapped register must leave flow control off
    reg_write(ADDR_UNMAPPED, 32'd1);
    add_item(REQ_TX_SLOT, 8'h00);
    wait_idle();

    // Directed: pending characters go out once flow control is on
    reg_write(ADDR_FLOW_CTRL, 32'd1);
    add_item(REQ_TX_SLOT, 8'h00);
    add_item(REQ_XON, 8'h00);
    add_item(REQ_TX_SLOT, 8'h00);
    add_item(REQ_TX_SLOT, 8'h00);
    add_item(REQ_TX_SLOT, 8'h00);
    add_item(REQ_XOFF, 8'h00);
    add_item(REQ_XOFF, 8'h00);
    add_item(REQ_TX_SLOT, 8'h00);
    add_item(REQ_XON, 8'h00, 1'b1);
    add_item(REQ_XON, 8'h00);
    add_item(REQ_TX_SLOT, 8'h00);
    wait_idle();

    // Random segments: idle pattern advances every two, flow control toggles
    for (int seg = 0; seg < 8; seg++) begin
      reg_write(ADDR_FLOW_CTRL, 32'(seg % 2));
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      build_segment(seg);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/uff_pkg.sv
hdl/uart_fifo_xon_xoff.sv
hdl/uff_checker.sv
bench/uart_fifo_xon_xoff_tb.sv
